// ----- rtl/core/tank_fill_and_pump_controller_unit_defines.svh -----
// ----------------------------------------------------------------------------
// tank fill and pump controller assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef TANK_FILL_AND_PUMP_CONTROLLER_UNIT_DEFINES_SVH
`define TANK_FILL_AND_PUMP_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define TFPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define TFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tfpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfpc_pkg
// types, codes and constants shared by the tank fill and pump controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfpc_pkg;

	// field widths
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned CIDX_W   = 3;

	// working widths of the fill arithmetic
	localparam int unsigned NUM_W  = 31;
	localparam int unsigned QUO_W  = 22;
	localparam int unsigned FI_W   = 14;
	localparam int unsigned DEP_W  = 10;
	localparam int unsigned PROD_W = NUM_W + QUO_W;

	// control constants
	localparam logic [WEIGHT_W-1:0] DEPTH_LIMIT  = 16'd1000;
	localparam logic [FI_W-1:0]     FILL_DEFAULT = 14'd1000;
	localparam logic [FI_W-1:0]     AVAIL_SCALE  = 14'd12495;
	localparam logic [16:0]         RUN_SCALE    = 17'd120000;

	// constant divisors and their reciprocals, floor(2^k / c)
	localparam int unsigned SH_1000 = 24;
	localparam int unsigned SH_833  = 31;
	localparam int unsigned SH_5    = 24;
	localparam logic [9:0] DIVC_1000 = 10'd1000;
	localparam logic [9:0] DIVC_833  = 10'd833;
	localparam logic [9:0] DIVC_5    = 10'd5;
	localparam logic [QUO_W-1:0] RCP_1000 = QUO_W'((64'd1 << SH_1000) / 64'd1000);
	localparam logic [QUO_W-1:0] RCP_833  = QUO_W'((64'd1 << SH_833) / 64'd833);
	localparam logic [QUO_W-1:0] RCP_5    = QUO_W'((64'd1 << SH_5) / 64'd5);

	// configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_MAX_WEIGHT   = 3'd0,
		REG_HYSTERESIS   = 3'd1,
		REG_MAX_FILL_INC = 3'd2,
		REG_MIN_PUMP_WT  = 3'd3,
		REG_MIN_RECHARGE = 3'd4,
		REG_WELL_FRESH   = 3'd5,
		REG_MAX_RUN      = 3'd6,
		REG_PUMP_REST    = 3'd7
	} cfg_reg_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_EST_A,
		ST_FIX_A,
		ST_FILL,
		ST_RUN_MUL,
		ST_EST_B,
		ST_FIX_B,
		ST_SCALE,
		ST_EST_C,
		ST_FIX_C,
		ST_COMMIT
	} ctrl_state_t;

	// datapath operations
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_PREP,
		DP_EST,
		DP_FIX,
		DP_FILL,
		DP_RUN_MUL,
		DP_SCALE,
		DP_COMMIT
	} dp_op_t;

	// constant divider selection
	typedef enum logic [1:0] {
		DIV_1000,
		DIV_833,
		DIV_5
	} div_sel_t;

	// command word from controller to datapath
	typedef struct packed {
		dp_op_t   op;
		div_sel_t dsel;
	} dp_cmd_t;

endpackage

// ----- rtl/core/tfpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tfpc_ctrl
// sequencer for one tick: input capture, fill arithmetic steps, commit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output tfpc_pkg::dp_cmd_t cmd
);
	import tfpc_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        commit;
	logic        out_free;

	// output slot is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd.op    = DP_NOP;
		cmd.dsel  = DIV_1000;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op    = DP_LOAD;
					state_nxt = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.op    = DP_PREP;
				state_nxt = ST_EST_A;
			end
			ST_EST_A: begin
				cmd.op    = DP_EST;
				cmd.dsel  = DIV_1000;
				state_nxt = ST_FIX_A;
			end
			ST_FIX_A: begin
				cmd.op    = DP_FIX;
				cmd.dsel  = DIV_1000;
				state_nxt = ST_FILL;
			end
			ST_FILL: begin
				cmd.op    = DP_FILL;
				state_nxt = ST_RUN_MUL;
			end
			ST_RUN_MUL: begin
				cmd.op    = DP_RUN_MUL;
				state_nxt = ST_EST_B;
			end
			ST_EST_B: begin
				cmd.op    = DP_EST;
				cmd.dsel  = DIV_833;
				state_nxt = ST_FIX_B;
			end
			ST_FIX_B: begin
				cmd.op    = DP_FIX;
				cmd.dsel  = DIV_833;
				state_nxt = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.op    = DP_SCALE;
				state_nxt = ST_EST_C;
			end
			ST_EST_C: begin
				cmd.op    = DP_EST;
				cmd.dsel  = DIV_5;
				state_nxt = ST_FIX_C;
			end
			ST_FIX_C: begin
				cmd.op    = DP_FIX;
				cmd.dsel  = DIV_5;
				state_nxt = ST_COMMIT;
			end
			ST_COMMIT: begin
				// state and result word change together, once the slot is free
				if (out_free) begin
					cmd.op    = DP_COMMIT;
					commit    = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/tfpc_dpath.sv -----
// ----------------------------------------------------------------------------
// tfpc_dpath
// configuration registers, controller state, fill arithmetic and rule logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfpc_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tfpc_pkg::dp_cmd_t                  cmd,
	input  logic                               cfg_we,
	input  logic [tfpc_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [tfpc_pkg::CFG_W-1:0]         cfg_data,
	input  logic [tfpc_pkg::TIME_W-1:0]        now_ms,
	input  logic [tfpc_pkg::WEIGHT_W-1:0]      weight,
	input  logic [tfpc_pkg::WEIGHT_W-1:0]      well_depth,
	input  logic [tfpc_pkg::TIME_W-1:0]        well_good_time,
	input  logic                               run_enable,
	output logic                               valve_open,
	output logic                               well_on,
	output logic                               pump_on
);
	import tfpc_pkg::*;

	// configuration registers
	logic [WEIGHT_W-1:0] max_weight_q;
	logic [WEIGHT_W-1:0] hysteresis_q;
	logic [WEIGHT_W-1:0] max_fill_inc_q;
	logic [WEIGHT_W-1:0] min_pump_wt_q;
	logic [TIME_W-1:0]   min_recharge_q;
	logic [TIME_W-1:0]   well_fresh_q;
	logic [TIME_W-1:0]   max_run_q;
	logic [TIME_W-1:0]   pump_rest_q;

	// controller state
	logic                valve_q;
	logic                well_q;
	logic                pump_q;
	logic [WEIGHT_W-1:0] fill_stop_q;
	logic [TIME_W-1:0]   run_limit_q;
	logic [TIME_W-1:0]   open_time_q;
	logic [TIME_W-1:0]   close_time_q;
	logic [TIME_W-1:0]   pump_stop_q;

	// captured tick
	logic [TIME_W-1:0]   now_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [WEIGHT_W-1:0] depth_q;
	logic [TIME_W-1:0]   good_q;
	logic                run_q;

	// working registers
	logic [NUM_W-1:0] num_q;
	logic [QUO_W-1:0] quo_q;
	logic [FI_W-1:0]  fi_q;
	logic             fresh_q;
	logic             recharge_q;
	logic             run_over_q;
	logic             rest_q;

	// combinational helpers
	logic [WEIGHT_W-1:0] depth_diff;
	logic [DEP_W-1:0]    depth_avail;
	logic [23:0]         avail_prod;
	logic [QUO_W-1:0]    rcp;
	logic [9:0]          divc;
	logic [PROD_W-1:0]   est_prod;
	logic [QUO_W-1:0]    est_quo;
	logic [QUO_W:0]      quo_inc;
	logic [32:0]         fix_prod;
	logic [FI_W-1:0]     avail;
	logic [FI_W-1:0]     fi_sel;
	logic [30:0]         run_prod;
	logic [23:0]         scale6;
	logic [TIME_W-1:0]   run_cand;
	logic [TIME_W-1:0]   run_new;
	logic [WEIGHT_W:0]   wt_plus_hys;
	logic [WEIGHT_W:0]   minp_plus_hys;
	logic [WEIGHT_W:0]   stop_sum;
	logic [WEIGHT_W-1:0] stop_sat;
	logic                do_close;
	logic                do_fill;
	logic                well_off;
	logic                pump_stop;
	logic                pump_start;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_weight_q   <= '0;
			hysteresis_q   <= '0;
			max_fill_inc_q <= '0;
			min_pump_wt_q  <= '0;
			min_recharge_q <= '0;
			well_fresh_q   <= '0;
			max_run_q      <= '0;
			pump_rest_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_WEIGHT:   max_weight_q   <= cfg_data[WEIGHT_W-1:0];
				REG_HYSTERESIS:   hysteresis_q   <= cfg_data[WEIGHT_W-1:0];
				REG_MAX_FILL_INC: max_fill_inc_q <= cfg_data[WEIGHT_W-1:0];
				REG_MIN_PUMP_WT:  min_pump_wt_q  <= cfg_data[WEIGHT_W-1:0];
				REG_MIN_RECHARGE: min_recharge_q <= cfg_data;
				REG_WELL_FRESH:   well_fresh_q   <= cfg_data;
				REG_MAX_RUN:      max_run_q      <= cfg_data;
				REG_PUMP_REST:    pump_rest_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// available fill from well depth, only meaningful up to the depth limit
	assign depth_diff  = DEPTH_LIMIT - depth_q;
	assign depth_avail = depth_diff[DEP_W-1:0];
	assign avail_prod  = depth_avail * AVAIL_SCALE;

	// constant divider: reciprocal estimate, then one correction step
	always_comb begin
		case (cmd.dsel)
			DIV_1000: begin
				rcp  = RCP_1000;
				divc = DIVC_1000;
			end
			DIV_833: begin
				rcp  = RCP_833;
				divc = DIVC_833;
			end
			DIV_5: begin
				rcp  = RCP_5;
				divc = DIVC_5;
			end
			default: begin
				rcp  = RCP_1000;
				divc = DIVC_1000;
			end
		endcase
	end

	assign est_prod = num_q * rcp;

	always_comb begin
		case (cmd.dsel)
			DIV_833: est_quo = est_prod[SH_833 +: QUO_W];
			DIV_5:   est_quo = est_prod[SH_5 +: QUO_W];
			default: est_quo = est_prod[SH_1000 +: QUO_W];
		endcase
	end

	assign quo_inc  = {1'b0, quo_q} + 1'b1;
	assign fix_prod = quo_inc * divc;

	// fill increment: with a fresh reading, the depth-based fill capped at max_fill_inc, else the default
	assign avail  = quo_q[FI_W-1:0];
	assign fi_sel = !fresh_q ? FILL_DEFAULT :
		(({2'b00, avail} < max_fill_inc_q) ? avail : max_fill_inc_q[FI_W-1:0]);

	// run time scaling, times 120000 then times 6
	assign run_prod = fi_q * RUN_SCALE;
	assign scale6   = {quo_q, 2'b00} + {1'b0, quo_q, 1'b0};

	// run limit, capped
	assign run_cand = {{(TIME_W-QUO_W){1'b0}}, quo_q};
	assign run_new  = (run_cand < max_run_q) ? run_cand : max_run_q;

	// fill stop weight, saturated
	assign stop_sum = {1'b0, weight_q} + {{(WEIGHT_W-FI_W+1){1'b0}}, fi_q};
	assign stop_sat = stop_sum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : stop_sum[WEIGHT_W-1:0];

	// threshold sums
	assign wt_plus_hys   = {1'b0, weight_q} + {1'b0, hysteresis_q};
	assign minp_plus_hys = {1'b0, min_pump_wt_q} + {1'b0, hysteresis_q};

	// valve and well rules in priority order
	always_comb begin
		do_close = 1'b0;
		do_fill  = 1'b0;
		well_off = 1'b0;
		if (!run_q) begin
			do_close = 1'b1;
		end else if ({1'b0, weight_q} >= ({1'b0, max_weight_q} + {1'b0, hysteresis_q})) begin
			well_off = 1'b1;
			do_close = 1'b1;
		end else if (weight_q >= max_weight_q) begin
			do_close = 1'b1;
		end else if (valve_q && (weight_q > fill_stop_q)) begin
			do_close = 1'b1;
		end else if (depth_q > DEPTH_LIMIT) begin
			do_close = 1'b1;
		end else if (valve_q && run_over_q) begin
			do_close = 1'b1;
		end else if (recharge_q && (wt_plus_hys < {1'b0, max_weight_q})) begin
			do_fill = 1'b1;
		end
	end

	// pump rules
	assign pump_stop  = (weight_q <= min_pump_wt_q);
	assign pump_start = !pump_stop && ({1'b0, weight_q} > minp_plus_hys) && !pump_q && rest_q;

	// tick capture and working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				now_q    <= now_ms;
				weight_q <= weight;
				depth_q  <= well_depth;
				good_q   <= well_good_time;
				run_q    <= run_enable;
			end
			DP_PREP: begin
				num_q      <= {{(NUM_W-24){1'b0}}, avail_prod};
				fresh_q    <= ((now_q - good_q) < well_fresh_q);
				recharge_q <= ((now_q - close_time_q) >= min_recharge_q);
				run_over_q <= ((now_q - open_time_q) >= run_limit_q);
				rest_q     <= ((now_q - pump_stop_q) >= pump_rest_q);
			end
			DP_EST: begin
				quo_q <= est_quo;
			end
			DP_FIX: begin
				if ({2'b00, num_q} >= fix_prod) begin
					quo_q <= quo_inc[QUO_W-1:0];
				end
			end
			DP_FILL: begin
				fi_q <= fi_sel;
			end
			DP_RUN_MUL: begin
				num_q <= run_prod;
			end
			DP_SCALE: begin
				num_q <= {{(NUM_W-24){1'b0}}, scale6};
			end
			default: begin
			end
		endcase
	end

	// controller state update at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_q      <= 1'b0;
			well_q       <= 1'b1;
			pump_q       <= 1'b0;
			fill_stop_q  <= '0;
			run_limit_q  <= '0;
			open_time_q  <= '0;
			close_time_q <= '0;
			pump_stop_q  <= '0;
		end else if (cmd.op == DP_COMMIT) begin
			if (do_close) begin
				if (valve_q) begin
					close_time_q <= now_q;
				end
				valve_q <= 1'b0;
				if (well_off) begin
					well_q <= 1'b0;
				end
			end else if (do_fill) begin
				run_limit_q <= run_new;
				if (!valve_q) begin
					fill_stop_q <= stop_sat;
					open_time_q <= now_q;
				end
				well_q  <= 1'b1;
				valve_q <= 1'b1;
			end
			if (pump_stop) begin
				if (pump_q) begin
					pump_stop_q <= now_q;
				end
				pump_q <= 1'b0;
			end else if (pump_start) begin
				pump_q <= 1'b1;
			end
		end
	end

	assign valve_open = valve_q;
	assign well_on    = well_q;
	assign pump_on    = pump_q;

endmodule

// ----- rtl/core/tank_fill_and_pump_controller_unit.sv -----
// ----------------------------------------------------------------------------
// tank_fill_and_pump_controller_unit
// fill valve, well contactor and delivery pump control, one word per tick
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry one tick word (time, weight, well
// depth, last good well time, run enable); it is taken when in_valid is high
// and in_stall is low. output channel: out_valid / out_stall carry the valve,
// well and pump states after that tick.
// the result word is registered at the commit step after the fill arithmetic,
// which runs as three constant divisions, each a reciprocal multiply on one
// shared multiplier and a correction step.
// the sequencer handles one tick at a time: in_stall stays high from the
// taken tick until its commit.
// stall: a finished word waits in the output register while in_stall drops
// and the next tick is taken; that tick holds before its commit until the
// waiting word has gone.
// reset: valve closed, well on, pump off, timers, fill stop and configuration registers zero.
// configuration: cfg_we writes cfg_data to register cfg_index; the user
// writes only while no tick is in work, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tank_fill_and_pump_controller_unit_defines.svh"

module tank_fill_and_pump_controller_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tfpc_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [tfpc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tfpc_pkg::TIME_W-1:0]   now_ms,
	input  logic [tfpc_pkg::WEIGHT_W-1:0] weight,
	input  logic [tfpc_pkg::WEIGHT_W-1:0] well_depth,
	input  logic [tfpc_pkg::TIME_W-1:0]   well_good_time,
	input  logic                          run_enable,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          valve_open,
	output logic                          well_on,
	output logic                          pump_on
);
	import tfpc_pkg::*;

	dp_cmd_t cmd;

	// sequencer
	tfpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath
	tfpc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.now_ms         (now_ms),
		.weight         (weight),
		.well_depth     (well_depth),
		.well_good_time (well_good_time),
		.run_enable     (run_enable),
		.valve_open     (valve_open),
		.well_on        (well_on),
		.pump_on        (pump_on)
	);

	// checks
	`TFPC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "tick taken but block not busy")
	`TFPC_ASSERT_NOW(a_valve_needs_well, valve_open, well_on, "valve open with well off")
	`TFPC_ASSERT_NOW(a_state_at_commit, !$stable({valve_open, well_on, pump_on}), out_valid, "outputs changed without a result word")

endmodule
